@@ design/book_walk_impact_price_macros.svh @@
// assertion helpers
`ifndef BOOK_WALK_IMPACT_PRICE_MACROS_SVH
`define BOOK_WALK_IMPACT_PRICE_MACROS_SVH
`define BWIP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("violated");
`define BWIP_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("violated");
`endif

@@ design/bwip_pkg.sv @@
`default_nettype none
package bwip_pkg;
	localparam int PRICE_W = 44;
	localparam int QTY_W   = 32;
	localparam int TGT_W   = 20;
	localparam int TOT_W   = 64;
	localparam int LVL_W   = 2;
	localparam logic [LVL_W-1:0] LVL_MAX = 2'd3;
	localparam logic [PRICE_W-1:0] PRICE_SAT = {PRICE_W{1'b1}};

	// one finished update handed from front to back
	typedef struct packed {
		logic [63:0]      ts;
		logic [63:0]      sq;
		logic             bv;
		logic [TOT_W-1:0] btot;
		logic [LVL_W-1:0] blv;
		logic             av;
		logic [TOT_W-1:0] atot;
		logic [LVL_W-1:0] alv;
		logic [TGT_W-1:0] tgt;
	} upd_t;

	typedef struct packed {
		logic [63:0]        ts;
		logic [63:0]        sq;
		logic               bv;
		logic [PRICE_W-1:0] bp;
		logic [LVL_W-1:0]   blv;
		logic               av;
		logic [PRICE_W-1:0] ap;
		logic [LVL_W-1:0]   alv;
	} res_t;
endpackage
`default_nettype wire

@@ design/book_walk_impact_price.sv @@
// channel  | handshake        | payload
// config   | cfg_we           | cfg_wdata (fill target per side)
// level in | push / full      | bid/ask price+qty, last_level, timestamp, sequence_number
// result   | empty / pop      | out_timestamp ... ask_levels_used
// Each level item goes through the front as a multiply stage, then accumulate.
// A last-level item queues its update; the back runs a restoring divide for
// both sides at once, then holds the result until it is popped.
// Full holds while the front is busy or the 2-entry queue is full.
// arst_n clears all control and accumulators; target resets to 1.
`default_nettype none
module book_walk_impact_price #(
	parameter int BOOK_LEVELS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [19:0] cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic [43:0] bid_price,
	input  wire logic [31:0] bid_qty,
	input  wire logic [43:0] ask_price,
	input  wire logic [31:0] ask_qty,
	input  wire logic        last_level,
	input  wire logic [63:0] timestamp,
	input  wire logic [63:0] sequence_number,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      out_timestamp,
	output logic [63:0]      out_sequence,
	output logic             bid_valid,
	output logic [43:0]      bid_effective_price,
	output logic [1:0]       bid_levels_used,
	output logic             ask_valid,
	output logic [43:0]      ask_effective_price,
	output logic [1:0]       ask_levels_used
);
	logic [19:0] tgt_q;
	logic qp, qf, qe, qpop;
	bwip_pkg::upd_t qw, qr;
	bwip_pkg::res_t r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tgt_q <= 20'd1;
		else if (cfg_we) tgt_q <= cfg_wdata;
	end

	bwip_front #(.BOOK_LEVELS(BOOK_LEVELS)) u_front (.clk, .arst_n, .tgt(tgt_q), .push,
		.full, .bid_price, .bid_qty, .ask_price, .ask_qty, .last_level, .timestamp,
		.sequence_number, .q_push(qp), .q_full(qf), .q_data(qw));
	bwip_queue u_queue (.clk, .arst_n, .push(qp), .wdata(qw), .full(qf), .pop(qpop),
		.empty(qe), .rdata(qr));
	bwip_back u_back (.clk, .arst_n, .q_empty(qe), .q_pop(qpop), .q_data(qr), .empty,
		.pop, .res(r));

	assign out_timestamp = r.ts;
	assign out_sequence = r.sq;
	assign bid_valid = r.bv;
	assign bid_effective_price = r.bp;
	assign bid_levels_used = r.blv;
	assign ask_valid = r.av;
	assign ask_effective_price = r.ap;
	assign ask_levels_used = r.alv;
endmodule
`default_nettype wire

@@ design/bwip_front.sv @@
`default_nettype none
// accumulates level items, one at a time: multiply, then add
module bwip_front #(
	parameter int BOOK_LEVELS = 3
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [bwip_pkg::TGT_W-1:0] tgt,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [bwip_pkg::PRICE_W-1:0] bid_price,
	input  wire logic [bwip_pkg::QTY_W-1:0] bid_qty,
	input  wire logic [bwip_pkg::PRICE_W-1:0] ask_price,
	input  wire logic [bwip_pkg::QTY_W-1:0] ask_qty,
	input  wire logic                       last_level,
	input  wire logic [63:0]                timestamp,
	input  wire logic [63:0]                sequence_number,
	output logic                            q_push,
	input  wire logic                       q_full,
	output bwip_pkg::upd_t                  q_data
);
	localparam int POS_W = $clog2(BOOK_LEVELS + 1);
	localparam int PROD_W = bwip_pkg::TGT_W + bwip_pkg::PRICE_W;

	logic [POS_W-1:0] pos_q;
	logic [bwip_pkg::TOT_W-1:0] btot_q, atot_q;
	logic [bwip_pkg::TGT_W-1:0] bfil_q, afil_q;
	logic [bwip_pkg::LVL_W-1:0] blv_q, alv_q;
	logic bstop_q, astop_q;
	logic busy_q, use_s1, last_s1, bt_s1, at_s1;
	logic [PROD_W-1:0] bprod_s1, aprod_s1;
	logic [bwip_pkg::TGT_W-1:0] tgt_s1;
	logic [63:0] ts_s1, sq_s1;
	logic [bwip_pkg::TGT_W-1:0] bneed, aneed, btake, atake;
	logic btk, atk, acc;

	assign full = busy_q || q_full;
	assign acc = push && !full;
	assign bneed = tgt - bfil_q;
	assign aneed = tgt - afil_q;
	assign btake = ({12'd0, bneed} < bid_qty) ? bneed : bid_qty[bwip_pkg::TGT_W-1:0];
	assign atake = ({12'd0, aneed} < ask_qty) ? aneed : ask_qty[bwip_pkg::TGT_W-1:0];
	assign btk = !bstop_q && !(bfil_q >= tgt || bid_price == '0 || bid_qty == '0);
	assign atk = !astop_q && !(afil_q >= tgt || ask_price == '0 || ask_qty == '0);

	logic [bwip_pkg::TOT_W-1:0] bsum, asum;
	logic [bwip_pkg::LVL_W-1:0] blv_n, alv_n;
	always_comb begin
		bsum = btot_q + (bt_s1 ? {{(bwip_pkg::TOT_W-PROD_W){1'b0}}, bprod_s1} : '0);
		asum = atot_q + (at_s1 ? {{(bwip_pkg::TOT_W-PROD_W){1'b0}}, aprod_s1} : '0);
		blv_n = (bt_s1 && blv_q != bwip_pkg::LVL_MAX) ? blv_q + 2'd1 : blv_q;
		alv_n = (at_s1 && alv_q != bwip_pkg::LVL_MAX) ? alv_q + 2'd1 : alv_q;
		q_data = '{ts: ts_s1, sq: sq_s1, bv: tgt_s1 != '0 && bfil_q >= tgt_s1, btot: bsum,
			blv: blv_n, av: tgt_s1 != '0 && afil_q >= tgt_s1, atot: asum, alv: alv_n,
			tgt: tgt_s1};
	end
	assign q_push = busy_q && last_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			bprod_s1 <= btake * bid_price;
			aprod_s1 <= atake * ask_price;
			tgt_s1 <= tgt;
			ts_s1 <= timestamp;
			sq_s1 <= sequence_number;
			last_s1 <= last_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; use_s1 <= 1'b0; bt_s1 <= 1'b0; at_s1 <= 1'b0;
			pos_q <= '0; btot_q <= '0; atot_q <= '0; bfil_q <= '0; afil_q <= '0;
			blv_q <= '0; alv_q <= '0; bstop_q <= 1'b0; astop_q <= 1'b0;
		end else if (acc) begin
			busy_q <= 1'b1;
			use_s1 <= pos_q < POS_W'(BOOK_LEVELS);
			bt_s1 <= (pos_q < POS_W'(BOOK_LEVELS)) && btk;
			at_s1 <= (pos_q < POS_W'(BOOK_LEVELS)) && atk;
			if (pos_q < POS_W'(BOOK_LEVELS)) begin
				pos_q <= pos_q + 1'b1;
				if (!btk) bstop_q <= 1'b1; else bfil_q <= bfil_q + btake;
				if (!atk) astop_q <= 1'b1; else afil_q <= afil_q + atake;
			end
		end else if (busy_q) begin
			busy_q <= 1'b0;
			if (last_s1) begin
				pos_q <= '0; btot_q <= '0; atot_q <= '0; bfil_q <= '0; afil_q <= '0;
				blv_q <= '0; alv_q <= '0; bstop_q <= 1'b0; astop_q <= 1'b0;
			end else if (use_s1) begin
				btot_q <= bsum; atot_q <= asum; blv_q <= blv_n; alv_q <= alv_n;
			end
		end
	end
endmodule
`default_nettype wire

@@ design/bwip_queue.sv @@
`default_nettype none
// two-entry queue between front and back
module bwip_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bwip_pkg::upd_t wdata,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output bwip_pkg::upd_t      rdata
);
	bwip_pkg::upd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];
	always_ff @(posedge clk) if (push && !full) mem_q[wp_q] <= wdata;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= !wp_q;
			if (pop && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end
endmodule
`default_nettype wire

@@ design/bwip_back.sv @@
`default_nettype none
// change filter and restoring divider, one quotient bit per side per cycle
module bwip_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	output logic                q_pop,
	input  wire bwip_pkg::upd_t q_data,
	output logic                empty,
	input  wire logic           pop,
	output bwip_pkg::res_t      res
);
	localparam int TW = bwip_pkg::TOT_W;
	localparam int CW = $clog2(TW);
	typedef enum logic [2:0] {S_IDLE = 3'b001, S_DIV = 3'b010, S_OUT = 3'b100} st_t;
	st_t st_q;
	bwip_pkg::upd_t u_q;
	logic [TW-1:0] bn_q, an_q;
	logic [bwip_pkg::TGT_W:0] br_q, ar_q;
	logic [CW-1:0] cnt_q;
	logic wr_q, pbv_q, pav_q;
	logic [TW-1:0] pbt_q, pat_q;
	logic [bwip_pkg::LVL_W-1:0] pbl_q, pal_q;
	logic chg;
	logic [bwip_pkg::TGT_W+1:0] bt, at;

	assign chg = !wr_q || q_data.bv != pbv_q || (q_data.bv && q_data.btot != pbt_q)
		|| q_data.blv != pbl_q || q_data.av != pav_q || (q_data.av && q_data.atot != pat_q)
		|| q_data.alv != pal_q;
	assign q_pop = st_q == S_IDLE && !q_empty;
	assign empty = st_q != S_OUT;
	assign bt = {br_q, bn_q[TW-1]} - {2'b0, u_q.tgt};
	assign at = {ar_q, an_q[TW-1]} - {2'b0, u_q.tgt};

	always_comb begin
		res.ts = u_q.ts; res.sq = u_q.sq; res.blv = u_q.blv; res.alv = u_q.alv;
		res.bv = u_q.bv; res.av = u_q.av;
		res.bp = !u_q.bv ? '0 : (bn_q[TW-1:bwip_pkg::PRICE_W] != '0) ? bwip_pkg::PRICE_SAT
			: bn_q[bwip_pkg::PRICE_W-1:0];
		res.ap = !u_q.av ? '0 : (an_q[TW-1:bwip_pkg::PRICE_W] != '0) ? bwip_pkg::PRICE_SAT
			: an_q[bwip_pkg::PRICE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; wr_q <= 1'b0; pbv_q <= 1'b0; pav_q <= 1'b0;
			pbt_q <= '0; pat_q <= '0; pbl_q <= '0; pal_q <= '0; cnt_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (!q_empty && chg) begin
					wr_q <= 1'b1; pbv_q <= q_data.bv; pav_q <= q_data.av;
					pbt_q <= q_data.btot; pat_q <= q_data.atot;
					pbl_q <= q_data.blv; pal_q <= q_data.alv;
					cnt_q <= '0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(TW - 1)) st_q <= S_OUT;
				end
				S_OUT: if (pop) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE) begin
			u_q <= q_data; bn_q <= q_data.btot; an_q <= q_data.atot;
			br_q <= '0; ar_q <= '0;
		end else if (st_q == S_DIV) begin
			if (!bt[bwip_pkg::TGT_W+1]) begin
				br_q <= bt[bwip_pkg::TGT_W:0]; bn_q <= {bn_q[TW-2:0], 1'b1};
			end else begin
				br_q <= {br_q[bwip_pkg::TGT_W-1:0], bn_q[TW-1]}; bn_q <= {bn_q[TW-2:0], 1'b0};
			end
			if (!at[bwip_pkg::TGT_W+1]) begin
				ar_q <= at[bwip_pkg::TGT_W:0]; an_q <= {an_q[TW-2:0], 1'b1};
			end else begin
				ar_q <= {ar_q[bwip_pkg::TGT_W-1:0], an_q[TW-1]}; an_q <= {an_q[TW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

@@ design/book_walk_impact_price_checker.sv @@
`default_nettype none
`include "book_walk_impact_price_macros.svh"
module book_walk_impact_price_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic        bid_valid,
	input wire logic [43:0] bid_effective_price,
	input wire logic        ask_valid,
	input wire logic [43:0] ask_effective_price,
	input wire logic [63:0] out_sequence
)
;
	`BWIP_ASSERT_IMP(a_bid0, clk, arst_n, !empty && !bid_valid, bid_effective_price == '0)
	`BWIP_ASSERT_IMP(a_ask0, clk, arst_n, !empty && !ask_valid, ask_effective_price == '0)
	`BWIP_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_sequence))
endmodule
bind book_walk_impact_price book_walk_impact_price_checker u_chk (.clk, .arst_n, .empty,
	.pop, .bid_valid, .bid_effective_price, .ask_valid, .ask_effective_price, .out_sequence);
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;

	// one level of the book as driven on the input ports
	typedef struct {
		logic [43:0] bp;
		logic [31:0] bq;
		logic [43:0] ap;
		logic [31:0] aq;
		logic        last;
		logic [63:0] ts;
		logic [63:0] sq;
	} level_t;

	// one row of the directed table: a level, an optional target write before it,
	// and an optional typed-in result (has_fixed) checked against the predictor too
	typedef struct {
		bit             wr_tgt;
		logic [19:0]    tgt;
		level_t         lv;
		bit             has_fixed;
		bwip_pkg::res_t fixed;
	} row_t;

	localparam int HALF = 4;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [19:0] cfg_wdata = '0;
	logic        push = 1'b0;
	logic [43:0] bid_price = '0;
	logic [31:0] bid_qty = '0;
	logic [43:0] ask_price = '0;
	logic [31:0] ask_qty = '0;
	logic        last_level = 1'b0;
	logic [63:0] timestamp = '0;
	logic [63:0] sequence_number = '0;
	logic        pop = 1'b0;
	wire         full;
	wire         empty;
	wire  [63:0] out_timestamp;
	wire  [63:0] out_sequence;
	wire         bid_valid;
	wire  [43:0] bid_effective_price;
	wire  [1:0]  bid_levels_used;
	wire         ask_valid;
	wire  [43:0] ask_effective_price;
	wire  [1:0]  ask_levels_used;

	always #HALF clk = ~clk;

	book_walk_impact_price u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.push(push), .full(full),
		.bid_price(bid_price), .bid_qty(bid_qty),
		.ask_price(ask_price), .ask_qty(ask_qty),
		.last_level(last_level), .timestamp(timestamp),
		.sequence_number(sequence_number),
		.empty(empty), .pop(pop),
		.out_timestamp(out_timestamp), .out_sequence(out_sequence),
		.bid_valid(bid_valid), .bid_effective_price(bid_effective_price),
		.bid_levels_used(bid_levels_used),
		.ask_valid(ask_valid), .ask_effective_price(ask_effective_price),
		.ask_levels_used(ask_levels_used)
	);

	// ---------------------------------------------------------------
	// Sweep predictor: own copy of target and per-update accumulators
	// ---------------------------------------------------------------
	logic [19:0] sw_target;
	int unsigned sw_pos;
	logic [63:0] sw_btot, sw_atot;
	logic [20:0] sw_bfill, sw_afill;
	logic [1:0]  sw_btch, sw_atch;
	bit          sw_bstop, sw_astop;
	bit          last_bv, last_av, emitted_any;
	logic [63:0] last_btot, last_atot;
	logic [1:0]  last_blv, last_alv;

	bwip_pkg::res_t impact_q[$];   // expected impact-price results, oldest first
	int   mismatches = 0;
	bit   done_stim = 0;

	function automatic void sweep_clear();
		sw_pos = 0;
		sw_btot = '0; sw_atot = '0;
		sw_bfill = '0; sw_afill = '0;
		sw_btch = '0; sw_atch = '0;
		sw_bstop = 0; sw_astop = 0;
	endfunction

	// walk one side one level deeper
	function automatic void side_fill(inout logic [63:0] tot, inout logic [20:0] fill,
			inout logic [1:0] tch, inout bit stop,
			input logic [43:0] p, input logic [31:0] q);
		logic [20:0] need;
		logic [31:0] take;
		if (stop)
			return;
		if (fill >= {1'b0, sw_target} || p == 0 || q == 0) begin
			stop = 1;
			return;
		end
		if (tch != bwip_pkg::LVL_MAX)
			tch++;
		need = {1'b0, sw_target} - fill;
		take = (q < 32'(need)) ? q : 32'(need);
		tot += 64'(take) * 64'(p);
		fill += 21'(take);
	endfunction

	function automatic logic [43:0] eff_price(logic [63:0] tot, bit ok);
		logic [63:0] quo;
		if (!ok || sw_target == 0)
			return '0;
		quo = tot / 64'(sw_target);
		return (quo > 64'(bwip_pkg::PRICE_SAT)) ? bwip_pkg::PRICE_SAT : quo[43:0];
	endfunction

	// returns 1 and fills r when this level causes a result
	function automatic bit sweep_level(level_t lv, output bwip_pkg::res_t r);
		bit bv, av, chg;
		r = '0;
		if (sw_pos < 3) begin
			side_fill(sw_btot, sw_bfill, sw_btch, sw_bstop, lv.bp, lv.bq);
			side_fill(sw_atot, sw_afill, sw_atch, sw_astop, lv.ap, lv.aq);
			sw_pos++;
		end
		if (!lv.last)
			return 0;
		bv = sw_target != 0 && sw_bfill >= {1'b0, sw_target};
		av = sw_target != 0 && sw_afill >= {1'b0, sw_target};
		chg = !emitted_any || bv != last_bv || (bv && sw_btot != last_btot)
			|| sw_btch != last_blv || av != last_av
			|| (av && sw_atot != last_atot) || sw_atch != last_alv;
		if (chg) begin
			r.ts = lv.ts; r.sq = lv.sq;
			r.bv = bv; r.bp = eff_price(sw_btot, bv); r.blv = sw_btch;
			r.av = av; r.ap = eff_price(sw_atot, av); r.alv = sw_atch;
			last_bv = bv; last_btot = sw_btot; last_blv = sw_btch;
			last_av = av; last_atot = sw_atot; last_alv = sw_atch;
			emitted_any = 1;
		end
		sweep_clear();
		return chg;
	endfunction

	// ---------------------------------------------------------------
	// Result side: stall pattern plus field compare at each transfer
	// ---------------------------------------------------------------
	int unsigned pop_phase = 0;
	int unsigned stall_mode = 0;
	always @(posedge clk) begin
		bwip_pkg::res_t got, want;
		if (arst_n && pop && !empty) begin
			got.ts = out_timestamp; got.sq = out_sequence;
			got.bv = bid_valid; got.bp = bid_effective_price; got.blv = bid_levels_used;
			got.av = ask_valid; got.ap = ask_effective_price; got.alv = ask_levels_used;
			if (impact_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result ts=%h sq=%h", got.ts, got.sq);
			end else begin
				want = impact_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %p got %p", want, got);
				end
			end
		end
		// receiver: stall mode redrawn at random among always open, random stalls and a fixed pattern
		pop_phase++;
		if (pop_phase % 400 == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 3) != 0);
			default: pop <= (pop_phase % 7 < 2);
		endcase
	end

	// ---------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------
	int unsigned burst_left = 0;

	// hold one level on the ports until it is accepted; gaps between bursts.
	// push stays high after the transfer; whoever pauses next drops it.
	task automatic send_level(level_t lv);
		bwip_pkg::res_t r;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		bid_price <= lv.bp; bid_qty <= lv.bq;
		ask_price <= lv.ap; ask_qty <= lv.aq;
		last_level <= lv.last; timestamp <= lv.ts; sequence_number <= lv.sq;
		do @(posedge clk); while (full);
		if (sweep_level(lv, r))
			impact_q.push_back(r);
	endtask

	// wait for every expected result, then cover a no-result update in the back
	task automatic wait_idle();
		push <= 1'b0;
		while (impact_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_target(logic [19:0] t);
		wait_idle();
		cfg_we <= 1'b1; cfg_wdata <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		sw_target = t;
	endtask

	function automatic level_t mk(logic [43:0] bp, logic [31:0] bq, logic [43:0] ap,
			logic [31:0] aq, logic last, logic [63:0] ts, logic [63:0] sq);
		level_t l;
		l.bp = bp; l.bq = bq; l.ap = ap; l.aq = aq; l.last = last; l.ts = ts; l.sq = sq;
		return l;
	endfunction

	function automatic logic [43:0] rnd_price();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return bwip_pkg::PRICE_SAT;
			2: return 44'($urandom_range(1, 1000)) * 44'd1000000000;
			default: return {12'($urandom), $urandom};
		endcase
	endfunction

	function automatic logic [31:0] rnd_qty();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic level_t rnd_level(logic last);
		return mk(rnd_price(), rnd_qty(), rnd_price(), rnd_qty(), last,
			{$urandom, $urandom}, {$urandom, $urandom});
	endfunction

	row_t dir_rows[$];

	task automatic add_row(bit wr, logic [19:0] t, level_t lv, bit hf, bwip_pkg::res_t fx);
		row_t rw;
		rw.wr_tgt = wr; rw.tgt = t; rw.lv = lv; rw.has_fixed = hf; rw.fixed = fx;
		dir_rows.push_back(rw);
	endtask

	initial begin
		bwip_pkg::res_t fx, none;
		level_t lv;
		int unsigned n_lv, sent;
		logic [19:0] tgts[6];
		none = '0;
		sw_target = 20'd1;
		sweep_clear();
		emitted_any = 0;
		last_bv = 0; last_av = 0; last_btot = '0; last_atot = '0;
		last_blv = '0; last_alv = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first update after reset with target 1: the first level fills it, the second is not used
		fx = '0; fx.ts = 64'h11; fx.sq = 64'h1;
		fx.bv = 1; fx.bp = 44'd5; fx.blv = 2'd1;
		fx.av = 1; fx.ap = 44'd7; fx.alv = 2'd1;
		add_row(0, 0, mk(44'd5, 32'd1, 44'd7, 32'd1, 0, 0, 0), 0, none);
		add_row(0, 0, mk(44'd9, 32'd1, 44'd9, 32'd1, 1, 64'h11, 64'h1), 1, fx);
		// identical update: nothing emitted
		add_row(0, 0, mk(44'd5, 32'd1, 44'd7, 32'd1, 1, 64'h12, 64'h2), 0, none);
		// empty levels: both sides invalid, zero levels
		fx = '0; fx.ts = '1; fx.sq = '1;
		add_row(0, 0, mk(44'd0, 32'd5, 44'd5, 32'd0, 1, '1, '1), 1, fx);
		// zero target: invalid, no levels
		add_row(1, 20'd0, mk(bwip_pkg::PRICE_SAT, '1, bwip_pkg::PRICE_SAT, '1, 1,
			64'h3, 64'h3), 0, none);
		// max target, max price over three levels and an extra ignored level
		add_row(1, 20'hFFFFF, mk(bwip_pkg::PRICE_SAT, 32'd1000, bwip_pkg::PRICE_SAT, '1,
			0, 0, 0), 0, none);
		add_row(0, 0, mk(bwip_pkg::PRICE_SAT, 32'd1000, 44'd1, 32'd1, 0, 0, 0), 0, none);
		add_row(0, 0, mk(bwip_pkg::PRICE_SAT, '1, 44'd1, 32'd1, 0, 0, 0), 0, none);
		add_row(0, 0, mk(44'd1, '1, 44'd1, '1, 1, 64'h4, 64'h4), 0, none);
		// short fill over three levels at target 100
		add_row(1, 20'd100, mk(44'd10, 32'd30, 44'd20, 32'd40, 0, 0, 0), 0, none);
		add_row(0, 0, mk(44'd11, 32'd30, 44'd0, 32'd40, 0, 0, 0), 0, none);
		add_row(0, 0, mk(44'd12, 32'd30, 44'd20, 32'd40, 1, 64'h5, 64'h5), 0, none);
		// target changed mid update: extra levels past three
		add_row(0, 0, mk(44'd10, 32'd60, 44'd10, 32'd60, 0, 0, 0), 0, none);
		add_row(1, 20'd50, mk(44'd10, 32'd60, 44'd10, 32'd60, 0, 0, 0), 0, none);
		add_row(0, 0, mk(44'd1, 32'd1, 44'd1, 32'd1, 0, 0, 0), 0, none);
		add_row(0, 0, mk(44'd1, 32'd1, 44'd1, 32'd1, 1, 64'h6, 64'h6), 0, none);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].wr_tgt)
				set_target(dir_rows[i].tgt);
			if (dir_rows[i].has_fixed) begin
				// the typed-in row must agree with the predictor as well
				send_level(dir_rows[i].lv);
				if (impact_q.size() == 0 || impact_q[$] !== dir_rows[i].fixed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("directed row %0d: predictor disagrees", i);
				end
			end else
				send_level(dir_rows[i].lv);
		end

		// random updates, mostly well formed, over a sweep of target settings
		tgts = '{20'd1, 20'hFFFFF, 20'd0, 20'd37, 20'd1000, 20'd5};
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			set_target(tgts[ph]);
			while (sent < 150 * (ph + 1)) begin
				n_lv = ($urandom_range(0, 9) < 7) ? 3 : $urandom_range(1, 5);
				for (int k = 1; k <= n_lv; k++) begin
					lv = rnd_level(k == n_lv);
					if ($urandom_range(0, 2) != 0 && tgts[ph] > 1) begin
						lv.bq = $urandom_range(1, 2 * tgts[ph]);
						lv.aq = $urandom_range(1, 2 * tgts[ph]);
					end
					send_level(lv);
					sent++;
				end
				// hold off now and then until everything expected is back
				if ($urandom_range(0, 40) == 0) begin
					push <= 1'b0;
					while (impact_q.size() != 0)
						@(posedge clk);
				end
			end
		end
		push <= 1'b0;
		done_stim = 1;
	end

	// run end and timeout watch
	int unsigned cyc = 0;
	int unsigned quiet = 0;
	always @(posedge clk) begin
		cyc++;
		if (done_stim && impact_q.size() == 0)
			quiet++;
		if (cyc >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else if (quiet >= DRAIN_CYCLES) begin
			if (mismatches == 0)
				$display("status: pass");
			else
				$display("status: fail");
			$finish;
		end
	end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+design
design/bwip_pkg.sv
design/bwip_front.sv
design/bwip_queue.sv
design/bwip_back.sv
design/book_walk_impact_price.sv
design/book_walk_impact_price_checker.sv
tb/tb_top.sv
